>>> hw/rtl/rads_pkg.sv
// Shared types and constants for the return-address stack depth tracker.
// No dependencies; every other file in hw/rtl imports this package.
package rads_pkg;

   localparam int STACK_ENTRIES = 64;
   localparam int IDX_W         = (STACK_ENTRIES > 1) ? $clog2(STACK_ENTRIES) : 1;
   localparam int CNT_W         = $clog2(STACK_ENTRIES + 1);
   localparam int ADDR_W        = 64;
   localparam int DEPTH_W       = 32;
   localparam int CMD_W         = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH     = 2'd0,
      CMD_POP      = 2'd1,
      CMD_POP_LOST = 2'd2,
      CMD_DUMP     = 2'd3
   } cmd_type;

   // Chain movement, broadcast to every cell
   typedef enum logic [1:0] {
      SHIFT_HOLD,
      SHIFT_DOWN,
      SHIFT_UP
   } shift_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_DUMP
   } state_type;

   // Stack events for the depth tracker
   typedef struct packed {
      logic push;   // push with room
      logic pop;    // pop of either kind
      logic lost;   // pop with lost trace
   } stack_evt_type;

endpackage

>>> hw/rtl/rads_if.sv
// Valid/ready channel interfaces for request and response items.
// Depends on rads_pkg for field widths.
interface rads_req_if import rads_pkg::*;;
   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    command;
   logic [ADDR_W-1:0]   return_address;

   modport source (output valid, command, return_address, input ready);
   modport sink   (input valid, command, return_address, output ready);
endinterface

interface rads_rsp_if import rads_pkg::*;;
   logic                      valid;
   logic                      ready;
   logic [ADDR_W-1:0]         address;
   logic                      entry_valid;
   logic                      last;
   logic signed [DEPTH_W-1:0] logical_depth;
   logic [DEPTH_W-1:0]        max_span;
   logic                      overflow;

   modport source (output valid, address, entry_valid, last, logical_depth, max_span,
                   overflow, input ready);
   modport sink   (input valid, address, entry_valid, last, logical_depth, max_span,
                   overflow, output ready);
endinterface

>>> hw/rtl/rads_cell.sv
// One stack cell: holds a single return address and shifts to a neighbour.
// Depends on rads_pkg.
module rads_cell import rads_pkg::*; (
   input  logic              clock,
   input  shift_type         shift_op,
   input  logic [ADDR_W-1:0] from_lower,
   input  logic [ADDR_W-1:0] from_upper,
   output logic [ADDR_W-1:0] entry_q
);

   logic [ADDR_W-1:0] entry_ff, entry_in;

   always_comb begin
      case (shift_op)
         SHIFT_DOWN: entry_in = from_lower;
         SHIFT_UP:   entry_in = from_upper;
         default:    entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_q = entry_ff;

endmodule

>>> hw/rtl/rads_depth.sv
// Entry count, underflow offset, logical depth, peak, low-water and span.
// Depends on rads_pkg.
module rads_depth import rads_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  stack_evt_type             evt,
   output logic [CNT_W-1:0]          count,
   output logic signed [DEPTH_W-1:0] depth,
   output logic [DEPTH_W-1:0]        max_span
);

   logic [CNT_W-1:0]          count_ff, count_in;
   logic signed [DEPTH_W-1:0] offset_ff, offset_in;
   logic signed [DEPTH_W-1:0] depth_ff, depth_in;
   logic signed [DEPTH_W-1:0] low_ff, low_in;
   logic signed [DEPTH_W-1:0] peak_ff, peak_in;
   logic [DEPTH_W-1:0]        span_ff, span_in;

   logic signed [DEPTH_W-1:0] depth_inc, depth_dec, offset_dec;
   logic [DEPTH_W-1:0]        span_cand;
   logic                      empty;

   assign empty      = (count_ff == '0);
   assign depth_inc  = depth_ff + DEPTH_W'(1);
   assign depth_dec  = depth_ff - DEPTH_W'(1);
   assign offset_dec = offset_ff - DEPTH_W'(1);

   always_comb begin
      count_in  = count_ff;
      offset_in = offset_ff;
      depth_in  = depth_ff;
      low_in    = low_ff;
      peak_in   = peak_ff;
      if (evt.push) begin
         count_in = count_ff + CNT_W'(1);
         depth_in = depth_inc;
         if (depth_inc > peak_ff) begin
            peak_in = depth_inc;
         end
      end else if (evt.pop) begin
         if (!empty) begin
            count_in = count_ff - CNT_W'(1);
            depth_in = depth_dec;
         end else if (!evt.lost) begin
            offset_in = offset_dec;
            depth_in  = depth_dec;
            if (offset_dec < low_ff) begin
               low_in = offset_dec;
            end
         end
      end
   end

   // peak >= 0 >= low, so the unsigned difference is the true span. Span only
   // grows when peak or low moves, so folding it in every cycle is equivalent.
   assign span_cand = $unsigned(peak_ff) - $unsigned(low_ff);
   assign span_in   = (span_cand > span_ff) ? span_cand : span_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         offset_ff <= '0;
         depth_ff  <= '0;
         low_ff    <= '0;
         peak_ff   <= '0;
         span_ff   <= '0;
      end else begin
         count_ff  <= count_in;
         offset_ff <= offset_in;
         depth_ff  <= depth_in;
         low_ff    <= low_in;
         peak_ff   <= peak_in;
         span_ff   <= span_in;
      end
   end

   assign count    = count_ff;
   assign depth    = depth_ff;
   assign max_span = span_in;

endmodule

>>> hw/rtl/return_address_stack_depth_tracker.sv
// Top level: return-address stack as a chain of shifting cells, with depth tracking.
// Depends on rads_pkg, rads_if, rads_cell and rads_depth.
//
//   channel   dir  payload                                                    handshake
//   req_port  in   command, return_address                                    valid/ready
//   rsp_port  out  address, entry_valid, last, logical_depth, max_span, overflow  valid/ready
//
// Push, pop and lost pop: the chain shifts on accept in ST_IDLE; in ST_UPDATE the span is
// folded and the result registered once the response register is free.
// Dump: the accept, then one full rotation of the cell ring in ST_DUMP;
// the entries leave from the tail cell oldest first. An empty dump goes through ST_UPDATE.
// Reset clears the counters, state, dump step and response valid; cell contents are not cleared.
// A full response register holds ST_UPDATE and each emitting dump step until rsp_port.ready.
module return_address_stack_depth_tracker import rads_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   rads_req_if.sink   req_port,
   rads_rsp_if.source rsp_port
);

   localparam int LAST = STACK_ENTRIES - 1;

   state_type                 state_ff, state_in;
   logic [IDX_W-1:0]          step_ff, step_in;
   logic [ADDR_W-1:0]         addr_ff, addr_in;
   logic                      hit_ff, hit_in;
   logic                      ovf_ff, ovf_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]         rsp_addr_ff, rsp_addr_in;
   logic                      rsp_hit_ff, rsp_hit_in;
   logic                      rsp_last_ff, rsp_last_in;
   logic signed [DEPTH_W-1:0] rsp_depth_ff, rsp_depth_in;
   logic [DEPTH_W-1:0]        rsp_span_ff, rsp_span_in;
   logic                      rsp_ovf_ff, rsp_ovf_in;

   logic [ADDR_W-1:0]         cell_q [STACK_ENTRIES];
   logic [ADDR_W-1:0]         head_in;
   shift_type                 shift_op;
   stack_evt_type             evt;

   logic [CNT_W-1:0]          count;
   logic signed [DEPTH_W-1:0] depth;
   logic [DEPTH_W-1:0]        max_span;

   cmd_type                   cmd;
   logic                      accept, full, empty, out_free;
   logic                      is_pop, take_entry;
   logic [IDX_W-1:0]          tail_idx;
   logic                      dump_emit, dump_adv, dump_end;
   logic                      load_single, load_dump;

   // ---- cell chain ----
   for (genvar i = 0; i < STACK_ENTRIES; i++) begin : g_cell
      logic [ADDR_W-1:0] lower, upper;
      if (i == 0) begin : g_head
         assign lower = head_in;
      end else begin : g_body
         assign lower = cell_q[i-1];
      end
      if (i == LAST) begin : g_tail
         assign upper = '0;
      end else begin : g_inner
         assign upper = cell_q[i+1];
      end
      rads_cell u_cell (
         .clock      (clock),
         .shift_op   (shift_op),
         .from_lower (lower),
         .from_upper (upper),
         .entry_q    (cell_q[i])
      );
   end

   rads_depth u_depth (
      .clock    (clock),
      .reset    (reset),
      .evt      (evt),
      .count    (count),
      .depth    (depth),
      .max_span (max_span)
   );

   // ---- decode ----
   assign cmd        = cmd_type'(req_port.command);
   assign accept     = req_port.valid && req_port.ready;
   assign full       = (count == CNT_W'(STACK_ENTRIES));
   assign empty      = (count == '0);
   assign out_free   = !rsp_valid_ff || rsp_port.ready;
   assign is_pop     = (cmd == CMD_POP) || (cmd == CMD_POP_LOST);
   assign take_entry = is_pop && !empty;

   // During a dump the tail cell holds the entry that started at tail_idx
   assign tail_idx   = IDX_W'(LAST) - step_ff;
   assign dump_emit  = (CNT_W'(tail_idx) < count);
   assign dump_adv   = (state_ff == ST_DUMP) && (!dump_emit || out_free);
   assign dump_end   = (step_ff == IDX_W'(LAST));

   // ---- next state ----
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (cmd == CMD_DUMP && !empty) ? ST_DUMP : ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_DUMP: begin
            if (dump_adv && dump_end) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ---- outputs of the sequencer ----
   always_comb begin
      req_port.ready = 1'b0;
      shift_op       = SHIFT_HOLD;
      head_in        = req_port.return_address;
      evt            = '0;
      load_single    = 1'b0;
      load_dump      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_port.ready = 1'b1;
            // ready is high here, so valid alone marks the accept
            if (req_port.valid) begin
               evt.push = (cmd == CMD_PUSH) && !full;
               evt.pop  = is_pop;
               evt.lost = (cmd == CMD_POP_LOST);
               if (cmd == CMD_PUSH && !full) begin
                  shift_op = SHIFT_DOWN;
               end else if (take_entry) begin
                  shift_op = SHIFT_UP;
               end
            end
         end
         ST_UPDATE: begin
            load_single = out_free;
         end
         ST_DUMP: begin
            head_in   = cell_q[LAST];
            load_dump = dump_adv && dump_emit;
            if (dump_adv) begin
               shift_op = SHIFT_DOWN;
            end
         end
         default: ;
      endcase
   end

   // ---- item and response registers ----
   always_comb begin
      addr_in      = addr_ff;
      hit_in       = hit_ff;
      ovf_in       = ovf_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_port.ready;
      rsp_addr_in  = rsp_addr_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_depth_in = rsp_depth_ff;
      rsp_span_in  = rsp_span_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      if (accept) begin
         addr_in = take_entry ? cell_q[0] : '0;
         hit_in  = take_entry;
         ovf_in  = (cmd == CMD_PUSH) && full;
         step_in = '0;
      end
      if (dump_adv) begin
         step_in = dump_end ? '0 : step_ff + IDX_W'(1);
      end
      if (load_single) begin
         rsp_valid_in = 1'b1;
         rsp_addr_in  = addr_ff;
         rsp_hit_in   = hit_ff;
         rsp_last_in  = 1'b1;
         rsp_depth_in = depth;
         rsp_span_in  = max_span;
         rsp_ovf_in   = ovf_ff;
      end else if (load_dump) begin
         rsp_valid_in = 1'b1;
         rsp_addr_in  = cell_q[LAST];
         rsp_hit_in   = 1'b1;
         rsp_last_in  = (tail_idx == '0);
         rsp_depth_in = depth;
         rsp_span_in  = max_span;
         rsp_ovf_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff      <= addr_in;
      hit_ff       <= hit_in;
      ovf_ff       <= ovf_in;
      rsp_addr_ff  <= rsp_addr_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_depth_ff <= rsp_depth_in;
      rsp_span_ff  <= rsp_span_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_port.valid         = rsp_valid_ff;
   assign rsp_port.address       = rsp_addr_ff;
   assign rsp_port.entry_valid   = rsp_hit_ff;
   assign rsp_port.last          = rsp_last_ff;
   assign rsp_port.logical_depth = rsp_depth_ff;
   assign rsp_port.max_span      = rsp_span_ff;
   assign rsp_port.overflow      = rsp_ovf_ff;

endmodule
